/* hdl/nfia_pkg.sv */
// Shared types and constants for the next-fit identifier allocator.
`timescale 1ns / 1ps

package nfia_pkg;

   // Width of the identifier fields on the request and response ports
   localparam int IDENT_W = 11;

   // Wide enough to compare any identifier against the largest MAX_ID
   localparam int WIDE_W = 17;

   // The bitmap is kept as words of this many bits
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_QUERY   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

endpackage

/* hdl/next_fit_id_allocator.sv */
// Next-fit identifier allocator: bitmap memory, word scanner and control sequencer.
`timescale 1ns / 1ps

// Hands out identifiers 1..MAX_ID, releases them and answers queries.
// Request channel (req_*): action and ident, taken when req_valid is high and
// req_stall is low. Response channel (rsp_*): one response per request, held
// in an output register until the receiver drops rsp_stall.
// The allocation bitmap lives in a memory of 32-bit words with one write
// port and one registered read port. The scanner, used by allocate, examines
// one word per cycle: it masks out taken and out-of-range bits and picks the
// lowest free bit with a two's-complement isolate. Release and query read one
// word and finish, passing from acceptance through the memory read and the
// finish state to rsp_valid; the unused action code reads no word and goes
// straight to the finish state. Allocate scans 1 to (MAX_ID+32)/32 + 1 words,
// which is 65 for the default. The block takes one request at a time;
// req_stall is high from acceptance until the response has moved into the
// output register.
// Reset: the sequencer first sweeps the memory clearing one word per cycle,
// all (MAX_ID+32)/32 words (64 at the default), with req_stall high meanwhile.
// When the receiver stalls, the finished response waits in the work
// registers and the next request is taken as soon as it moves out.
module next_fit_id_allocator
   import nfia_pkg::*;
#(
   parameter int MAX_ID = 2047
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [IDENT_W-1:0] req_ident,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDENT_W-1:0] rsp_granted_ident,
   output logic               rsp_status,
   output logic               rsp_is_allocated,
   output logic               rsp_not_found
);

   // Bitmap geometry, all derived from MAX_ID
   localparam int WORDS = (MAX_ID + WORD_BITS) / WORD_BITS;
   localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDW   = WA_W + BIT_W;
   localparam int VIS_W = $clog2(WORDS + 1);
   localparam logic [WA_W-1:0]      LAST_WA   = WA_W'(WORDS - 1);
   localparam logic [WORD_BITS-1:0] LAST_MASK =
      WORD_BITS'((64'd1 << ((MAX_ID % WORD_BITS) + 1)) - 64'd1);
   localparam logic [IDW-1:0]       MAX_IDW   = IDW'(MAX_ID);
   localparam logic [WIDE_W-1:0]    MAX_WIDE  = WIDE_W'(MAX_ID);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Bitmap memory and its registered read port
   logic [WORD_BITS-1:0] used_map_ff [WORDS];
   logic [WORD_BITS-1:0] map_rd_ff;
   logic                 mem_we;
   logic [WA_W-1:0]      mem_wa;
   logic [WA_W-1:0]      mem_ra;
   logic [WORD_BITS-1:0] mem_wd;

   // Sequencer and work registers
   state_type            state_ff, state_in;
   action_type           act_ff, act_in;
   logic [WA_W-1:0]      clr_ff, clr_in;
   logic [WA_W-1:0]      word_ff, word_in;
   logic [BIT_W-1:0]     sb_ff, sb_in;
   logic                 first_ff, first_in;
   logic                 range_ff, range_in;
   logic [VIS_W-1:0]     visits_ff, visits_in;
   logic [IDW-1:0]       last_ff, last_in;
   logic [IDENT_W-1:0]   res_granted_ff, res_granted_in;
   logic                 res_status_ff, res_status_in;
   logic                 res_alloc_ff, res_alloc_in;
   logic                 res_nf_ff, res_nf_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDENT_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic                 rsp_alloc_ff, rsp_alloc_in;
   logic                 rsp_nf_ff, rsp_nf_in;

   // Datapath helpers
   logic [WIDE_W-1:0]    ident_wide;
   logic                 ident_ok;
   logic [IDW-1:0]       ident_int;
   logic [IDW-1:0]       start_id;
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] start_mask;
   logic [WORD_BITS-1:0] free_vec;
   logic [WORD_BITS-1:0] low_free;
   logic [BIT_W-1:0]     free_pos;
   logic [IDW-1:0]       cand;
   logic [WIDE_W-1:0]    cand_wide;
   logic [WA_W-1:0]      next_word;
   logic                 bit_set;
   logic                 out_free;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_ident = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_is_allocated  = rsp_alloc_ff;
   assign rsp_not_found     = rsp_nf_ff;

   // Request decode: identifiers outside 1..MAX_ID never touch the bitmap
   assign ident_wide = WIDE_W'(req_ident);
   assign ident_ok   = (ident_wide != '0) && (ident_wide <= MAX_WIDE);
   assign ident_int  = ident_wide[IDW-1:0];
   assign start_id   = (last_ff >= MAX_IDW) ? IDW'(1) : last_ff + IDW'(1);

   // Scanner: keep bits 1..MAX_ID, skip bits below the start on the first word
   always_comb begin
      valid_mask = '1;
      if (word_ff == '0) begin
         valid_mask[0] = 1'b0;
      end
      if (word_ff == LAST_WA) begin
         valid_mask = valid_mask & LAST_MASK;
      end
   end

   assign start_mask = first_ff ? ({WORD_BITS{1'b1}} << sb_ff) : '1;
   assign free_vec   = ~map_rd_ff & valid_mask & start_mask;
   assign low_free   = free_vec & (~free_vec + WORD_BITS'(1));

   always_comb begin
      free_pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_free[i]) begin
            free_pos = free_pos | BIT_W'(i);
         end
      end
   end

   assign cand      = {word_ff, free_pos};
   assign cand_wide = WIDE_W'(cand);
   assign next_word = (word_ff == LAST_WA) ? '0 : word_ff + WA_W'(1);
   assign bit_set   = map_rd_ff[sb_ff] & range_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Sequencer next-state and register inputs
   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      clr_in         = clr_ff;
      word_in        = word_ff;
      sb_in          = sb_ff;
      first_in       = first_ff;
      range_in       = range_ff;
      visits_in      = visits_ff;
      last_in        = last_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      res_alloc_in   = res_alloc_ff;
      res_nf_in      = res_nf_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_alloc_in   = rsp_alloc_ff;
      rsp_nf_in      = rsp_nf_ff;
      mem_we         = 1'b0;
      mem_wa         = word_ff;
      mem_wd         = map_rd_ff;
      mem_ra         = word_ff;

      // Drop the response once the receiver has taken it
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + WA_W'(1);
            if (clr_ff == LAST_WA) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               act_in         = action_type'(req_action);
               res_granted_in = '0;
               res_status_in  = 1'b0;
               res_alloc_in   = 1'b0;
               res_nf_in      = 1'b0;
               case (action_type'(req_action))
                  ACT_ALLOC: begin
                     word_in   = start_id[IDW-1:BIT_W];
                     sb_in     = start_id[BIT_W-1:0];
                     first_in  = 1'b1;
                     visits_in = '0;
                     mem_ra    = start_id[IDW-1:BIT_W];
                     state_in  = ST_SCAN;
                  end
                  ACT_RELEASE, ACT_QUERY: begin
                     word_in  = ident_ok ? ident_int[IDW-1:BIT_W] : '0;
                     sb_in    = ident_int[BIT_W-1:0];
                     range_in = ident_ok;
                     mem_ra   = ident_ok ? ident_int[IDW-1:BIT_W] : '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            case (act_ff)
               ACT_ALLOC: begin
                  if (free_vec != '0) begin
                     // Mark the lowest free bit and record it as last granted
                     mem_we         = 1'b1;
                     mem_wd         = map_rd_ff | low_free;
                     last_in        = cand;
                     res_granted_in = cand_wide[IDENT_W-1:0];
                     state_in       = ST_FINISH;
                  end else if (visits_ff == VIS_W'(WORDS)) begin
                     // Every word seen, the start word twice: report full, change nothing
                     res_status_in = 1'b1;
                     state_in      = ST_FINISH;
                  end else begin
                     word_in   = next_word;
                     mem_ra    = next_word;
                     first_in  = 1'b0;
                     visits_in = visits_ff + VIS_W'(1);
                  end
               end
               ACT_RELEASE: begin
                  if (bit_set) begin
                     mem_we = 1'b1;
                     mem_wd = map_rd_ff & ~(WORD_BITS'(1) << sb_ff);
                  end
                  res_nf_in = !bit_set;
                  state_in  = ST_FINISH;
               end
               ACT_QUERY: begin
                  res_alloc_in = bit_set;
                  state_in     = ST_FINISH;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         ST_FINISH: begin
            // Hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_status_in  = res_status_ff;
               rsp_alloc_in   = res_alloc_ff;
               rsp_nf_in      = res_nf_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State, work and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff         <= act_in;
      word_ff        <= word_in;
      sb_ff          <= sb_in;
      first_ff       <= first_in;
      range_ff       <= range_in;
      visits_ff      <= visits_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      res_alloc_ff   <= res_alloc_in;
      res_nf_ff      <= res_nf_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_alloc_ff   <= rsp_alloc_in;
      rsp_nf_ff      <= rsp_nf_in;
   end

   // Bitmap memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         used_map_ff[mem_wa] <= mem_wd;
      end
      map_rd_ff <= used_map_ff[mem_ra];
   end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the next-fit identifier allocator.
`timescale 1ns / 1ps
module tb_top;
   import nfia_pkg::*;

   localparam int MAX_ID       = 2047;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 1350;
   localparam int DRAIN_ITEMS  = 1200;  // releases issued once the map is full
   localparam int TAIL_ITEMS   = 200;   // last requests go out with no idling
   localparam int HOLD_AFTER   = 120;   // responses seen before the long hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_WAIT  = 80;    // longest allocate scan plus margin

   // Two copies of the allocator state: one plans the stimulus ahead of time,
   // the other predicts responses as requests are accepted.
   localparam int COPY_PLAN  = 0;
   localparam int COPY_CHECK = 1;

   typedef struct packed {
      logic [IDENT_W-1:0] granted;
      logic               status;
      logic               is_allocated;
      logic               not_found;
   } id_reply_type;

   typedef struct {
      action_type         act;
      logic [IDENT_W-1:0] ident;
      bit                 wait_idle;  // hold until every response is back
   } id_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action = ACT_ALLOC;
   logic [IDENT_W-1:0] req_ident = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [IDENT_W-1:0] rsp_granted_ident;
   logic               rsp_status;
   logic               rsp_is_allocated;
   logic               rsp_not_found;

   // Allocator state per copy: bitmap and last identifier granted
   bit [MAX_ID:0]      id_map  [2];
   bit [IDENT_W-1:0]   last_id [2];

   id_request_type     pending_requests [$];
   id_reply_type       expected_replies [$];
   logic [IDENT_W-1:0] owned_ids [$];

   int  accepted_count = 0;
   int  results_seen = 0;     // written with nonblocking assignments only
   int  cycle_count = 0;
   int  error_count = 0;
   int  gap_left = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   bit  hold_done = 1'b0;
   bit  quiet_tail = 1'b0;
   int  grant_count = 0;
   int  full_count = 0;
   int  stale_count = 0;
   int  hit_count = 0;

   logic idle_window;

   // Allow idling only in alternate stretches of 256 responses
   assign idle_window = results_seen[8];

   next_fit_id_allocator #(
      .MAX_ID (MAX_ID)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_ident         (req_ident),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_ident (rsp_granted_ident),
      .rsp_status        (rsp_status),
      .rsp_is_allocated  (rsp_is_allocated),
      .rsp_not_found     (rsp_not_found)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hold reset at the start, then release it for good
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Step forward through the identifier space, wrapping from MAX_ID to 1
   function automatic logic [IDENT_W-1:0] wrap_next(logic [IDENT_W-1:0] id);
      return (int'(id) >= MAX_ID) ? IDENT_W'(1) : id + 1'b1;
   endfunction

   // Apply one request to the chosen copy of the state and return the response
   function automatic id_reply_type step_allocator(int copy, action_type act,
                                                   logic [IDENT_W-1:0] ident);
      id_reply_type       reply;
      logic [IDENT_W-1:0] cand;
      bit                 found;
      bit                 held;
      int                 n;
      reply = '0;
      found = 1'b0;
      // Identifier zero (or anything past MAX_ID) is never allocated
      held = (int'(ident) >= 1) && (int'(ident) <= MAX_ID) && id_map[copy][ident];
      case (act)
         ACT_ALLOC: begin
            cand = wrap_next(last_id[copy]);
            for (n = 0; n < MAX_ID && !found; n++) begin
               if (!id_map[copy][cand])
                  found = 1'b1;
               else
                  cand = wrap_next(cand);
            end
            if (found) begin
               id_map[copy][cand] = 1'b1;
               last_id[copy] = cand;
               reply.granted = cand;
            end else begin
               // every identifier taken: report full and leave the state alone
               reply.status = 1'b1;
            end
         end
         ACT_RELEASE: begin
            if (held)
               id_map[copy][ident] = 1'b0;
            else
               reply.not_found = 1'b1;
         end
         ACT_QUERY: begin
            reply.is_allocated = held;
         end
         default: begin
            // unused code: no operation, all fields zero
         end
      endcase
      return reply;
   endfunction

   // Queue a request and track which identifiers the plan believes are held
   function automatic id_reply_type plan_request(action_type act,
                                                 logic [IDENT_W-1:0] ident,
                                                 bit wait_idle);
      id_request_type item;
      id_reply_type   reply;
      int             k;
      reply = step_allocator(COPY_PLAN, act, ident);
      if (act == ACT_ALLOC && !reply.status)
         owned_ids.push_back(reply.granted);
      if (act == ACT_RELEASE && !reply.not_found) begin
         for (k = 0; k < owned_ids.size(); k++) begin
            if (owned_ids[k] == ident) begin
               owned_ids.delete(k);
               break;
            end
         end
      end
      item.act = act;
      item.ident = ident;
      item.wait_idle = wait_idle;
      pending_requests.push_back(item);
      return reply;
   endfunction

   // Pick an identifier the plan holds, or any identifier when none is held
   function automatic logic [IDENT_W-1:0] some_owned();
      if (owned_ids.size() == 0)
         return IDENT_W'($urandom);
      return owned_ids[$urandom_range(0, owned_ids.size() - 1)];
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("tb_top: response %0d, %s: got %0d, expected %0d",
               results_seen, field, got, want);
      error_count++;
   endtask

   // Request driver: advance to the next queued request after each acceptance,
   // hold the payload steady while stalled, and predict at the accepting edge.
   always @(posedge clock) begin : drive_requests
      id_request_type item;
      id_reply_type   reply;
      bit             took;
      took = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (took) begin
            // The block serves requests strictly in order, so predict now
            reply = step_allocator(COPY_CHECK, action_type'(req_action), req_ident);
            expected_replies.push_back(reply);
            accepted_count++;
            if (!quiet_tail && idle_window && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 8);
         end
         if (!req_valid || took) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         (!pending_requests[0].wait_idle ||
                          results_seen == accepted_count)) begin
               item = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_action <= item.act;
               req_ident <= item.ident;
            end else begin
               req_valid <= 1'b0;
            end
         end
         quiet_tail <= pending_requests.size() < TAIL_ITEMS;
      end
   end

   // Response receiver: one long hold-off early on so the block backs up and
   // stalls its request side, then short random stall bursts in alternate
   // stretches, and none at all in the tail.
   always @(posedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet_tail && !idle_window && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Response checker: compare every accepted response with the oldest prediction
   always @(posedge clock) begin : check_replies
      id_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("response with no request outstanding",
                            32'(rsp_granted_ident), 32'd0);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_granted_ident !== want.granted)
               report_mismatch("granted_ident", 32'(rsp_granted_ident), 32'(want.granted));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_is_allocated !== want.is_allocated)
               report_mismatch("is_allocated", 32'(rsp_is_allocated), 32'(want.is_allocated));
            if (rsp_not_found !== want.not_found)
               report_mismatch("not_found", 32'(rsp_not_found), 32'(want.not_found));
            if (want.granted != 0) grant_count++;
            if (want.status) full_count++;
            if (want.not_found) stale_count++;
            if (want.is_allocated) hit_count++;
            results_seen <= results_seen + 1;
         end
      end
   end

   // Build the whole request stream up front, then wait for it to drain
   initial begin : plan_and_close
      id_reply_type reply;
      int           pick;
      int           n;
      bit           timed_out;
      timed_out = 1'b0;

      // Directed opening on an empty map
      void'(plan_request(ACT_QUERY,   IDENT_W'(1),    1'b0));  // nothing held yet
      void'(plan_request(ACT_RELEASE, IDENT_W'(5),    1'b0));  // release of a free id
      void'(plan_request(ACT_ALLOC,   '1,             1'b0));  // ident ignored: grant 1
      void'(plan_request(ACT_ALLOC,   '0,             1'b0));
      void'(plan_request(ACT_ALLOC,   IDENT_W'(1365), 1'b0));
      void'(plan_request(ACT_QUERY,   IDENT_W'(1),    1'b0));
      void'(plan_request(ACT_QUERY,   '0,             1'b0));  // zero is never held
      void'(plan_request(ACT_QUERY,   IDENT_W'(MAX_ID), 1'b0));
      void'(plan_request(ACT_RELEASE, IDENT_W'(2),    1'b0));
      void'(plan_request(ACT_RELEASE, IDENT_W'(2),    1'b0));  // second release misses
      void'(plan_request(ACT_RELEASE, '0,             1'b0));  // out of range
      void'(plan_request(ACT_RELEASE, IDENT_W'(MAX_ID), 1'b0));
      void'(plan_request(ACT_NONE,    '1,             1'b0));  // unused code
      void'(plan_request(ACT_NONE,    '0,             1'b0));
      void'(plan_request(ACT_ALLOC,   IDENT_W'(682),  1'b0));  // next fit skips freed 2
      void'(plan_request(ACT_QUERY,   IDENT_W'(2),    1'b0));
      void'(plan_request(ACT_QUERY,   IDENT_W'(4),    1'b0));

      // Pause until the block is idle, then fill the map until allocate reports full
      reply = plan_request(ACT_ALLOC, IDENT_W'($urandom), 1'b1);
      while (!reply.status)
         reply = plan_request(ACT_ALLOC, IDENT_W'($urandom), 1'b0);
      void'(plan_request(ACT_ALLOC,   IDENT_W'($urandom), 1'b0));  // still full
      void'(plan_request(ACT_QUERY,   IDENT_W'(MAX_ID),   1'b0));
      void'(plan_request(ACT_RELEASE, IDENT_W'(MAX_ID),   1'b0));
      void'(plan_request(ACT_RELEASE, IDENT_W'(1),        1'b0));
      // One free slot lies before the wrap and one after it: the scans run the map and wrap
      void'(plan_request(ACT_ALLOC,   IDENT_W'($urandom), 1'b0));
      void'(plan_request(ACT_ALLOC,   IDENT_W'($urandom), 1'b0));
      void'(plan_request(ACT_ALLOC,   IDENT_W'($urandom), 1'b0));

      // Thin the full map out with well-formed releases
      for (n = 0; n < DRAIN_ITEMS; n++)
         void'(plan_request(ACT_RELEASE, some_owned(), 1'b0));

      // Random mix, mostly legal traffic on held identifiers plus some noise
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            void'(plan_request(ACT_ALLOC, IDENT_W'($urandom), 1'b0));
         else if (pick < 65)
            void'(plan_request(ACT_RELEASE, some_owned(), 1'b0));
         else if (pick < 72)
            void'(plan_request(ACT_RELEASE, IDENT_W'($urandom), 1'b0));
         else if (pick < 84)
            void'(plan_request(ACT_QUERY, some_owned(), 1'b0));
         else if (pick < 95)
            void'(plan_request(ACT_QUERY, IDENT_W'($urandom), 1'b0));
         else
            void'(plan_request(ACT_NONE, IDENT_W'($urandom), 1'b0));
      end

      // Wait for every request to go out and every response to come back
      while (!timed_out && (pending_requests.size() != 0 || req_valid ||
                            results_seen != accepted_count)) begin
         @(negedge clock);
         timed_out = cycle_count >= CYCLE_LIMIT;
      end
      if (!timed_out)
         repeat (SETTLE_WAIT) @(negedge clock);

      $display("tb_top: %0d requests answered: %0d grants, %0d full replies,",
               results_seen, grant_count, full_count);
      $display("tb_top: %0d stale releases, %0d query hits", stale_count, hit_count);
      $display("tb_top: map filled to capacity and thinned out, with a long response hold-off");
      if (timed_out)
         $display("tb_top: timed out after %0d cycles", cycle_count);
      if (!timed_out && error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
